// ===== sv/vss_pkg.sv =====
`timescale 1ns / 1ps

package vss_pkg;

  // field widths fixed by the interface
  localparam int LINE_CFG_W   = 10;
  localparam int ROW_W        = 8;
  localparam int OFFSET_OUT_W = 16;
  localparam int FRAME_W      = 16;
  localparam int TONE_W       = 25;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;
  // first_active_line + visible_rows * (row_repeat + 1) fits in 17 bits
  localparam int END_W        = 17;

  // parameter defaults
  localparam int LINE_BITS_DEF   = 10;
  localparam int OFFSET_BITS_DEF = 16;

  // register reset values
  localparam logic [LINE_CFG_W-1:0] LINES_PER_FRAME_RST   = 10'd262;
  localparam logic [LINE_CFG_W-1:0] VSYNC_END_LINE_RST    = 10'd3;
  localparam logic [LINE_CFG_W-1:0] FIRST_ACTIVE_LINE_RST = 10'd40;
  localparam logic [ROW_W-1:0]      ROW_REPEAT_RST        = 8'd1;
  localparam logic [ROW_W-1:0]      BYTES_PER_LINE_RST    = 8'd16;
  localparam logic [ROW_W-1:0]      VISIBLE_ROWS_RST      = 8'd96;
  localparam logic [LINE_CFG_W-1:0] DATA_CAPTURE_LINE_RST = 10'd0;
  localparam logic                  DATA_CAPTURE_ON_RST   = 1'b0;

  typedef enum logic [2:0] {
    REG_LINES_PER_FRAME,
    REG_VSYNC_END_LINE,
    REG_FIRST_ACTIVE_LINE,
    REG_ROW_REPEAT,
    REG_BYTES_PER_LINE,
    REG_VISIBLE_ROWS,
    REG_DATA_CAPTURE_LINE,
    REG_DATA_CAPTURE_ON
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_CAPTURE,
    ACT_TONE,
    ACT_RESUME
  } action_t;

  typedef enum logic [1:0] {
    LK_NONE,
    LK_DRAW,
    LK_CAPTURE,
    LK_DATA
  } line_kind_t;

  typedef enum logic [1:0] {
    PH_VSYNC,
    PH_BLANK,
    PH_ACTIVE
  } phase_t;

  typedef enum logic [1:0] {
    CAP_IDLE,
    CAP_REQ,
    CAP_BUSY
  } capture_t;

  typedef enum logic [1:0] {
    DM_NORMAL,
    DM_CAPTURE,
    DM_OFF
  } draw_mode_t;

endpackage

// ===== sv/vss_cmd_if.sv =====
`timescale 1ns / 1ps

interface vss_cmd_if;
  logic                                valid;
  logic                                ready;
  vss_pkg::action_t                    action;
  logic signed [vss_pkg::TONE_W-1:0]   tone_count;

  modport source (output valid, action, tone_count, input ready);
  modport sink   (input valid, action, tone_count, output ready);
endinterface

// ===== sv/vss_res_if.sv =====
`timescale 1ns / 1ps

interface vss_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 sync_vertical;
  vss_pkg::line_kind_t                  line_kind;
  logic [vss_pkg::OFFSET_OUT_W-1:0]     row_offset;
  logic [vss_pkg::LINE_CFG_W-1:0]       line_number;
  logic [vss_pkg::FRAME_W-1:0]          frame_count;
  logic                                 vblank_start;
  logic                                 tone_stop;

  modport source (output valid, sync_vertical, line_kind, row_offset, line_number,
                  frame_count, vblank_start, tone_stop, input ready);
  modport sink   (input valid, sync_vertical, line_kind, row_offset, line_number,
                  frame_count, vblank_start, tone_stop, output ready);
endinterface

// ===== sv/video_scanline_sequencer.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake        payload
// cmd       in    valid / ready    action, tone_count
// res       out   valid / ready    sync_vertical, line_kind, row_offset, line_number,
//                                  frame_count, vblank_start, tone_stop
// apb       in    psel / penable   paddr, pwdata, pwrite -> prdata, pready (always 1)
//
// one beat per cycle sustained while res is ready; every cmd beat yields exactly one res beat
// a beat passes through the cmd input register, then the res result register
// all sequencing state updates when a beat moves from the input register to the result
// register, in a single pass of compare / add logic (one small 8x9 multiply for active end)
// a stalled res keeps its beat; cmd stays ready while the input register is free
// rst is synchronous, active high; it clears control state and loads register defaults

module video_scanline_sequencer #(
  parameter int LINE_BITS   = vss_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = vss_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vss_pkg::PADDR_W-1:0]   paddr,
  input  logic [vss_pkg::PDATA_W-1:0]   pwdata,
  output logic [vss_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  vss_cmd_if.sink                       cmd,
  vss_res_if.source                     res
);

  // common compare width for the line counter against the 10-bit line registers
  localparam int CW = (LINE_BITS > vss_pkg::LINE_CFG_W) ? LINE_BITS : vss_pkg::LINE_CFG_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [vss_pkg::LINE_CFG_W-1:0] lines_per_frame;
  logic [vss_pkg::LINE_CFG_W-1:0] vsync_end_line;
  logic [vss_pkg::LINE_CFG_W-1:0] first_active_line;
  logic [vss_pkg::ROW_W-1:0]      row_repeat;
  logic [vss_pkg::ROW_W-1:0]      bytes_per_line;
  logic [vss_pkg::ROW_W-1:0]      visible_rows;
  logic [vss_pkg::LINE_CFG_W-1:0] data_capture_line;
  logic                           data_capture_on;

  logic             cfg_wr;
  vss_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // registers sit on 4-byte boundaries
  assign cfg_idx = vss_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_per_frame   <= vss_pkg::LINES_PER_FRAME_RST;
      vsync_end_line    <= vss_pkg::VSYNC_END_LINE_RST;
      first_active_line <= vss_pkg::FIRST_ACTIVE_LINE_RST;
      row_repeat        <= vss_pkg::ROW_REPEAT_RST;
      bytes_per_line    <= vss_pkg::BYTES_PER_LINE_RST;
      visible_rows      <= vss_pkg::VISIBLE_ROWS_RST;
      data_capture_line <= vss_pkg::DATA_CAPTURE_LINE_RST;
      data_capture_on   <= vss_pkg::DATA_CAPTURE_ON_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vss_pkg::REG_LINES_PER_FRAME:   lines_per_frame   <= pwdata[vss_pkg::LINE_CFG_W-1:0];
        vss_pkg::REG_VSYNC_END_LINE:    vsync_end_line    <= pwdata[vss_pkg::LINE_CFG_W-1:0];
        vss_pkg::REG_FIRST_ACTIVE_LINE: first_active_line <= pwdata[vss_pkg::LINE_CFG_W-1:0];
        vss_pkg::REG_ROW_REPEAT:        row_repeat        <= pwdata[vss_pkg::ROW_W-1:0];
        vss_pkg::REG_BYTES_PER_LINE:    bytes_per_line    <= pwdata[vss_pkg::ROW_W-1:0];
        vss_pkg::REG_VISIBLE_ROWS:      visible_rows      <= pwdata[vss_pkg::ROW_W-1:0];
        vss_pkg::REG_DATA_CAPTURE_LINE: data_capture_line <= pwdata[vss_pkg::LINE_CFG_W-1:0];
        vss_pkg::REG_DATA_CAPTURE_ON:   data_capture_on   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back, zero extended
  always_comb begin
    unique case (cfg_idx)
      vss_pkg::REG_LINES_PER_FRAME:   prdata = vss_pkg::PDATA_W'(lines_per_frame);
      vss_pkg::REG_VSYNC_END_LINE:    prdata = vss_pkg::PDATA_W'(vsync_end_line);
      vss_pkg::REG_FIRST_ACTIVE_LINE: prdata = vss_pkg::PDATA_W'(first_active_line);
      vss_pkg::REG_ROW_REPEAT:        prdata = vss_pkg::PDATA_W'(row_repeat);
      vss_pkg::REG_BYTES_PER_LINE:    prdata = vss_pkg::PDATA_W'(bytes_per_line);
      vss_pkg::REG_VISIBLE_ROWS:      prdata = vss_pkg::PDATA_W'(visible_rows);
      vss_pkg::REG_DATA_CAPTURE_LINE: prdata = vss_pkg::PDATA_W'(data_capture_line);
      vss_pkg::REG_DATA_CAPTURE_ON:   prdata = vss_pkg::PDATA_W'(data_capture_on);
      default:                        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input register and pipeline handshake
  // ---------------------------------------------------------------------------
  logic                               in_valid;
  vss_pkg::action_t                   in_action;
  logic [vss_pkg::TONE_W-1:0]         in_tone;
  logic                               out_valid;
  logic                               adv;      // result register can take a beat
  logic                               commit;   // beat moves into the result register

  assign adv       = !out_valid || res.ready;
  assign commit    = in_valid && adv;
  assign cmd.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_action <= cmd.action;
      in_tone   <= cmd.tone_count;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing state
  // ---------------------------------------------------------------------------
  vss_pkg::phase_t            phase,           phase_next;
  logic [LINE_BITS-1:0]       scan_line,       scan_line_next;
  logic [vss_pkg::ROW_W-1:0]  repeat_left,     repeat_left_next;
  logic [OFFSET_BITS-1:0]     row_byte_offset, row_byte_offset_next;
  logic [vss_pkg::FRAME_W-1:0] frames_started, frames_started_next;
  vss_pkg::capture_t          capture_state,   capture_state_next;
  vss_pkg::draw_mode_t        draw_mode,       draw_mode_next;
  logic [vss_pkg::TONE_W-1:0] tone_left,       tone_left_next;
  logic                       vertical_pulse,  vertical_pulse_next;

  // shared decode of the current beat
  logic                     is_tick;
  logic [CW-1:0]            scan_ext;
  logic [LINE_BITS-1:0]     scan_inc;
  logic [vss_pkg::ROW_W:0]  rep_plus1;
  logic [vss_pkg::END_W-1:0] active_end;
  logic                     frame_start;   // vsync phase, counter at or past the last line
  logic                     vsync_done;    // vsync phase reaches its end line
  logic                     arm_active;    // blanking reaches the first active line
  logic                     blank_end;     // blanking reaches the last line
  logic                     data_hit;      // blanking line chosen for data capture
  logic                     active_last;   // last line of the active picture
  logic                     row_step;      // row repeats used up, step the offset

  assign is_tick   = (in_action == vss_pkg::ACT_TICK);
  assign scan_ext  = CW'(scan_line);
  assign scan_inc  = scan_line + 1'b1;
  assign rep_plus1 = {1'b0, row_repeat} + 1'b1;
  // end line is computed unwrapped, so a value past the counter range is never met
  assign active_end = vss_pkg::END_W'(first_active_line)
                    + vss_pkg::END_W'(visible_rows) * vss_pkg::END_W'(rep_plus1);

  assign frame_start = is_tick && (phase != vss_pkg::PH_BLANK) && (phase != vss_pkg::PH_ACTIVE)
                       && (scan_ext >= CW'(lines_per_frame));
  assign vsync_done  = is_tick && (phase != vss_pkg::PH_BLANK) && (phase != vss_pkg::PH_ACTIVE)
                       && !frame_start && (scan_ext == CW'(vsync_end_line));
  assign arm_active  = is_tick && (phase == vss_pkg::PH_BLANK)
                       && (scan_ext == CW'(first_active_line));
  assign blank_end   = is_tick && (phase == vss_pkg::PH_BLANK) && !arm_active
                       && (scan_ext == CW'(lines_per_frame));
  assign data_hit    = is_tick && (phase == vss_pkg::PH_BLANK) && data_capture_on
                       && (scan_ext == CW'(data_capture_line));
  assign active_last = (vss_pkg::END_W'(scan_line) + 1'b1) == active_end;
  assign row_step    = (repeat_left == '0);

  // next state
  always_comb begin : next_state
    phase_next           = phase;
    scan_line_next       = scan_line;
    repeat_left_next     = repeat_left;
    row_byte_offset_next = row_byte_offset;
    frames_started_next  = frames_started;
    capture_state_next   = capture_state;
    draw_mode_next       = draw_mode;
    tone_left_next       = tone_left;
    vertical_pulse_next  = vertical_pulse;

    unique case (in_action)
      vss_pkg::ACT_CAPTURE: capture_state_next = vss_pkg::CAP_REQ;
      vss_pkg::ACT_TONE:    tone_left_next     = in_tone;
      vss_pkg::ACT_RESUME:  draw_mode_next     = vss_pkg::DM_NORMAL;
      vss_pkg::ACT_TICK: begin
        scan_line_next = scan_inc;
        unique case (phase)
          vss_pkg::PH_ACTIVE: begin
            if (row_step) begin
              repeat_left_next     = row_repeat;
              row_byte_offset_next = row_byte_offset + OFFSET_BITS'(bytes_per_line);
            end else begin
              repeat_left_next = repeat_left - 1'b1;
            end
            if (active_last) begin
              phase_next = vss_pkg::PH_BLANK;
            end
          end
          vss_pkg::PH_BLANK: begin
            if (arm_active) begin
              row_byte_offset_next = '0;
              repeat_left_next     = row_repeat;
              phase_next           = vss_pkg::PH_ACTIVE;
              // one-frame capture: requested -> capturing -> drawing off
              if (capture_state == vss_pkg::CAP_REQ) begin
                capture_state_next = vss_pkg::CAP_BUSY;
                draw_mode_next     = vss_pkg::DM_CAPTURE;
              end else if (capture_state == vss_pkg::CAP_BUSY) begin
                capture_state_next = vss_pkg::CAP_IDLE;
                draw_mode_next     = vss_pkg::DM_OFF;
              end
            end else if (blank_end) begin
              phase_next = vss_pkg::PH_VSYNC;
            end
            // data capture line wins over a capture arming on the same line
            if (data_hit) begin
              draw_mode_next = vss_pkg::DM_NORMAL;
            end
          end
          default: begin
            if (frame_start) begin
              vertical_pulse_next = 1'b1;
              scan_line_next      = LINE_BITS'(1);
              frames_started_next = frames_started + 1'b1;
              // negative tone count is endless, zero just reports a stop
              if (tone_left != '0 && !tone_left[vss_pkg::TONE_W-1]) begin
                tone_left_next = tone_left - 1'b1;
              end
            end else if (vsync_done) begin
              vertical_pulse_next = 1'b0;
              phase_next          = vss_pkg::PH_BLANK;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // result fields of the current beat
  logic                           o_sync_vertical;
  vss_pkg::line_kind_t            o_line_kind;
  logic [vss_pkg::OFFSET_OUT_W-1:0] o_row_offset;
  logic [vss_pkg::LINE_CFG_W-1:0] o_line_number;
  logic                           o_vblank_start;
  logic                           o_tone_stop;

  always_comb begin : outputs
    o_sync_vertical = vertical_pulse_next;
    o_line_kind     = vss_pkg::LK_NONE;
    o_row_offset    = '0;
    o_line_number   = frame_start ? '0 : vss_pkg::LINE_CFG_W'(scan_line);
    o_vblank_start  = blank_end;
    o_tone_stop     = frame_start && (tone_left == '0);
    if (is_tick && phase == vss_pkg::PH_ACTIVE) begin
      o_row_offset = vss_pkg::OFFSET_OUT_W'(row_byte_offset);
      unique case (draw_mode)
        vss_pkg::DM_NORMAL:  o_line_kind = vss_pkg::LK_DRAW;
        vss_pkg::DM_CAPTURE: o_line_kind = vss_pkg::LK_CAPTURE;
        default:             o_line_kind = vss_pkg::LK_NONE;
      endcase
    end else if (data_hit) begin
      o_line_kind = vss_pkg::LK_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= vss_pkg::PH_VSYNC;
      scan_line      <= '1;   // forces a frame start on the first tick
      repeat_left    <= '0;
      row_byte_offset <= '0;
      frames_started <= '0;
      capture_state  <= vss_pkg::CAP_IDLE;
      draw_mode      <= vss_pkg::DM_NORMAL;
      tone_left      <= '0;
      vertical_pulse <= 1'b0;
    end else if (commit) begin
      phase          <= phase_next;
      scan_line      <= scan_line_next;
      repeat_left    <= repeat_left_next;
      row_byte_offset <= row_byte_offset_next;
      frames_started <= frames_started_next;
      capture_state  <= capture_state_next;
      draw_mode      <= draw_mode_next;
      tone_left      <= tone_left_next;
      vertical_pulse <= vertical_pulse_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.sync_vertical <= o_sync_vertical;
      res.line_kind     <= o_line_kind;
      res.row_offset    <= o_row_offset;
      res.line_number   <= o_line_number;
      res.frame_count   <= frames_started_next;
      res.vblank_start  <= o_vblank_start;
      res.tone_stop     <= o_tone_stop;
    end
  end

  assign res.valid = out_valid;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // vertical pulse only lives in the vsync phase
  a_pulse_in_vsync: assert property (@(posedge clk) disable iff (rst)
    (phase != vss_pkg::PH_VSYNC) |-> !vertical_pulse)
    else $error("vertical pulse set outside vsync phase");

  // a tone stop is only reported on a frame start beat
  a_tone_stop_frame: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.tone_stop) |-> (res.line_number == '0 && res.sync_vertical))
    else $error("tone stop outside frame start");

  // a frame count change is presented right away as a frame start beat
  a_frame_beat: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && frames_started != $past(frames_started))
      |-> (res.valid && res.line_number == '0 && res.frame_count == frames_started))
    else $error("frame count moved without a frame start beat");

  // a beat waiting in the input register is not dropped while the result stalls
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |=> in_valid)
    else $error("input beat lost during stall");

endmodule

// ===== sim/video_scanline_sequencer_tb.sv =====
`timescale 1ns / 1ps

module video_scanline_sequencer_tb;
  import vss_pkg::*;

  // one predicted or observed scanline result, as carried by the result channel
  typedef struct packed {
    logic                    sync_vertical;
    line_kind_t              line_kind;
    logic [OFFSET_OUT_W-1:0] row_offset;
    logic [LINE_CFG_W-1:0]   line_number;
    logic [FRAME_W-1:0]      frame_count;
    logic                    vblank_start;
    logic                    tone_stop;
  } line_result_t;

  // scoreboard: keeps its own copy of the timing registers and of the line
  // sequencing state, predicts one result per accepted command beat and
  // checks result beats in order against those predictions
  class scanline_checker;
    // timing registers as last written
    logic [LINE_CFG_W-1:0] lines_per_frame, vsync_stop, first_active, capture_line;
    logic [ROW_W-1:0]      row_repeat, row_bytes, rows_shown;
    logic                  capture_line_on;
    // sequencing state
    phase_t                  phase;
    logic [LINE_CFG_W-1:0]   scan_line;
    logic [ROW_W-1:0]        repeats_left;
    logic [OFFSET_OUT_W-1:0] row_offset;
    logic [FRAME_W-1:0]      frames;
    capture_t                capture;
    draw_mode_t              draw;
    logic [TONE_W-1:0]       tone_left;
    logic                    vertical;
    // lines predicted but not yet seen on the result channel
    line_result_t            lines_due[$];
    int unsigned             mismatches, commands, lines_checked;
    int unsigned             frame_starts, tone_stops, vblanks;
    int unsigned             kind_seen[4];

    function new();
      lines_per_frame = LINES_PER_FRAME_RST;
      vsync_stop      = VSYNC_END_LINE_RST;
      first_active    = FIRST_ACTIVE_LINE_RST;
      row_repeat      = ROW_REPEAT_RST;
      row_bytes       = BYTES_PER_LINE_RST;
      rows_shown      = VISIBLE_ROWS_RST;
      capture_line    = DATA_CAPTURE_LINE_RST;
      capture_line_on = DATA_CAPTURE_ON_RST;
      phase           = PH_VSYNC;
      scan_line       = '1;
      repeats_left    = '0;
      row_offset      = '0;
      frames          = '0;
      capture         = CAP_IDLE;
      draw            = DM_NORMAL;
      tone_left       = '0;
      vertical        = 1'b0;
    endfunction

    function void set_register(reg_idx_t idx, int unsigned value);
      case (idx)
        REG_LINES_PER_FRAME:   lines_per_frame = value[LINE_CFG_W-1:0];
        REG_VSYNC_END_LINE:    vsync_stop      = value[LINE_CFG_W-1:0];
        REG_FIRST_ACTIVE_LINE: first_active    = value[LINE_CFG_W-1:0];
        REG_ROW_REPEAT:        row_repeat      = value[ROW_W-1:0];
        REG_BYTES_PER_LINE:    row_bytes       = value[ROW_W-1:0];
        REG_VISIBLE_ROWS:      rows_shown      = value[ROW_W-1:0];
        REG_DATA_CAPTURE_LINE: capture_line    = value[LINE_CFG_W-1:0];
        default:               capture_line_on = value[0];
      endcase
    endfunction

    // advance the sequencer by one command beat and queue the line it yields
    function void accept_command(action_t act, logic [TONE_W-1:0] tone);
      line_result_t r;
      int unsigned  active_end;
      r = '0;
      r.line_kind   = LK_NONE;
      r.line_number = scan_line;
      commands++;
      case (act)
        ACT_CAPTURE: capture = CAP_REQ;
        ACT_TONE:    tone_left = tone;
        ACT_RESUME:  draw = DM_NORMAL;
        default: begin
          case (phase)
            PH_ACTIVE: begin
              r.row_offset = row_offset;
              r.line_kind  = (draw == DM_NORMAL) ? LK_DRAW :
                             (draw == DM_CAPTURE) ? LK_CAPTURE : LK_NONE;
              if (repeats_left == 0) begin
                repeats_left = row_repeat;
                row_offset   = row_offset + row_bytes;
              end else begin
                repeats_left--;
              end
              // unwrapped compare, an end past the counter range never hits
              active_end = int'(first_active) + int'(rows_shown) * (int'(row_repeat) + 1);
              if (int'(scan_line) + 1 == active_end) phase = PH_BLANK;
              scan_line++;
            end
            PH_BLANK: begin
              if (scan_line == first_active) begin
                // arm the active phase; a pending capture walks one step on
                row_offset = '0;
                if (capture == CAP_REQ) begin
                  capture = CAP_BUSY;
                  draw    = DM_CAPTURE;
                end else if (capture == CAP_BUSY) begin
                  capture = CAP_IDLE;
                  draw    = DM_OFF;
                end
                repeats_left = row_repeat;
                phase        = PH_ACTIVE;
              end else if (scan_line == lines_per_frame) begin
                phase          = PH_VSYNC;
                r.vblank_start = 1'b1;
              end
              // data line wins over an arming on the same line
              if (capture_line_on && scan_line == capture_line) begin
                r.line_kind = LK_DATA;
                draw        = DM_NORMAL;
              end
              scan_line++;
            end
            default: begin
              if (scan_line >= lines_per_frame) begin
                vertical      = 1'b1;
                scan_line     = '0;
                r.line_number = '0;
                frames++;
                frame_starts++;
                if (tone_left != 0) begin
                  // negative count is endless
                  if (!tone_left[TONE_W-1]) tone_left--;
                end else begin
                  r.tone_stop = 1'b1;
                end
              end else if (scan_line == vsync_stop) begin
                vertical = 1'b0;
                phase    = PH_BLANK;
              end
              scan_line++;
            end
          endcase
        end
      endcase
      r.sync_vertical = vertical;
      r.frame_count   = frames;
      lines_due.push_back(r);
    endfunction

    function void check_line(line_result_t got);
      line_result_t want;
      lines_checked++;
      if (lines_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d with nothing pending: line %0d kind %0d",
                   lines_checked, got.line_number, got.line_kind);
        return;
      end
      want = lines_due.pop_front();
      if (got.sync_vertical !== want.sync_vertical || got.line_kind !== want.line_kind ||
          got.row_offset !== want.row_offset || got.line_number !== want.line_number ||
          got.frame_count !== want.frame_count || got.vblank_start !== want.vblank_start ||
          got.tone_stop !== want.tone_stop) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result beat %0d differs", lines_checked);
          $display("  expected sync %0d kind %0d offset %04h line %0d frame %0d vbl %0d stop %0d",
                   want.sync_vertical, want.line_kind, want.row_offset, want.line_number,
                   want.frame_count, want.vblank_start, want.tone_stop);
          $display("  actual   sync %0d kind %0d offset %04h line %0d frame %0d vbl %0d stop %0d",
                   got.sync_vertical, got.line_kind, got.row_offset, got.line_number,
                   got.frame_count, got.vblank_start, got.tone_stop);
        end
      end
      kind_seen[int'(want.line_kind)]++;
      tone_stops += want.tone_stop;
      vblanks    += want.vblank_start;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  vss_cmd_if cmd_bus ();
  vss_res_if res_bus ();

  scanline_checker board;

  // idle and stall rates in percent, changed from one part of the run to the next
  int unsigned src_idle_pct  = 20;
  int unsigned sink_stall_pct = 20;

  video_scanline_sequencer i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_bus),
    .res     (res_bus)
  );

  always #1 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("video_scanline_sequencer_tb NOT OK");
    $finish;
  end

  // watch both channels at the rising edge; a result beat is checked before the
  // command beat of the same edge is predicted (the two are never the same item)
  always @(posedge clk) begin : watch
    line_result_t seen;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        seen.sync_vertical = res_bus.sync_vertical;
        seen.line_kind     = res_bus.line_kind;
        seen.row_offset    = res_bus.row_offset;
        seen.line_number   = res_bus.line_number;
        seen.frame_count   = res_bus.frame_count;
        seen.vblank_start  = res_bus.vblank_start;
        seen.tone_stop     = res_bus.tone_stop;
        board.check_line(seen);
      end
      if (cmd_bus.valid && cmd_bus.ready)
        board.accept_command(cmd_bus.action, cmd_bus.tone_count);
    end
  end

  // result side: ready drops in bursts, never lowered and
  // raised in the same step
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
    end
  end

  // mostly tiny counts so tone stops come often, sometimes endless or large
  function automatic logic [TONE_W-1:0] pick_tone();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return TONE_W'($urandom_range(0, 4));
    if (roll < 8) return '1;
    return TONE_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // all driver tasks start and end just after a falling edge

  // one command beat; valid stays high into the next beat unless the next
  // one starts with an idle burst or the caller drains
  task automatic send_item(action_t act, logic [TONE_W-1:0] tone);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.action     <= act;
    cmd_bus.tone_count <= tone;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
  endtask

  // stop sending and wait for every pending line to come back
  task automatic wait_drain();
    cmd_bus.valid <= 1'b0;
    while (board.lines_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // setup then access cycle; the register takes the value at the access edge
  task automatic write_reg(reg_idx_t idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_timing(int unsigned lpf, int unsigned vse, int unsigned fa,
                              int unsigned rr, int unsigned bpl, int unsigned vr,
                              int unsigned dcl, int unsigned dco);
    write_reg(REG_LINES_PER_FRAME, lpf);
    write_reg(REG_VSYNC_END_LINE, vse);
    write_reg(REG_FIRST_ACTIVE_LINE, fa);
    write_reg(REG_ROW_REPEAT, rr);
    write_reg(REG_BYTES_PER_LINE, bpl);
    write_reg(REG_VISIBLE_ROWS, vr);
    write_reg(REG_DATA_CAPTURE_LINE, dcl);
    write_reg(REG_DATA_CAPTURE_ON, dco);
  endtask

  // short but well-formed frame: vsync, blank, active rows, blank up to the
  // frame end, with at most 48 lines per frame
  task automatic write_random_timing();
    int unsigned vse, fa, rr, vr, act_end, lpf, dcl;
    vse     = $urandom_range(1, 4);
    fa      = vse + $urandom_range(1, 8);
    rr      = $urandom_range(0, 3);
    vr      = $urandom_range(1, 6);
    act_end = fa + vr * (rr + 1);
    lpf     = act_end + $urandom_range(0, 12);
    case ($urandom_range(0, 2))
      0:       dcl = fa;   // data line on the arming line itself
      1:       dcl = $urandom_range(vse + 1, fa);
      default: dcl = $urandom_range(act_end, lpf);
    endcase
    write_timing(lpf, vse, fa, rr, $urandom_range(1, 255), vr, dcl,
                 ($urandom_range(0, 3) != 0) ? 1 : 0);
  endtask

  task automatic pick_gaps();
    case ($urandom_range(0, 2))
      0:       src_idle_pct = 0;
      1:       src_idle_pct = 10;
      default: src_idle_pct = 35;
    endcase
    case ($urandom_range(0, 2))
      0:       sink_stall_pct = 0;
      1:       sink_stall_pct = 10;
      default: sink_stall_pct = 35;
    endcase
  endtask

  // mostly line ticks; capture requests, resumes and tone loads mixed in
  task automatic send_random(int unsigned count);
    int unsigned roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)       send_item(ACT_CAPTURE, pick_tone());
      else if (roll < 8)  send_item(ACT_RESUME, pick_tone());
      else if (roll < 12) send_item(ACT_TONE, pick_tone());
      else                send_item(ACT_TICK, pick_tone());
    end
  endtask

  // tick until the sequencer sits on the line right after a frame start, so
  // the next timing setting begins from a clean frame
  task automatic run_to_frame_start();
    int unsigned guard;
    guard = 0;
    while (!(board.phase == PH_VSYNC && board.scan_line == 1) && guard < 2500) begin
      send_item(ACT_TICK, pick_tone());
      guard++;
    end
  endtask

  initial begin
    board              = new();
    cmd_bus.valid      = 1'b0;
    cmd_bus.action     = ACT_TICK;
    cmd_bus.tone_count = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part on the reset timing: frame start with no tone left, endless
    // and largest tone counts, every action, the step from vsync into blanking
    send_item(ACT_TICK, '0);
    send_item(ACT_TONE, '1);
    send_item(ACT_TICK, '0);
    send_item(ACT_TICK, '1);
    send_item(ACT_TONE, TONE_W'(24'hFFFFFF));
    send_item(ACT_TICK, '0);
    send_item(ACT_CAPTURE, '1);
    send_item(ACT_TICK, '0);
    send_item(ACT_RESUME, '0);
    send_item(ACT_TONE, '0);
    send_item(ACT_TICK, '1);
    send_item(ACT_TONE, TONE_W'(1));
    send_item(ACT_CAPTURE, '0);
    send_item(ACT_TICK, '0);

    // short random frames, each setting entered from a fresh frame start
    for (int p = 0; p < 4; p++) begin
      run_to_frame_start();
      wait_drain();
      write_random_timing();
      pick_gaps();
      send_random(60);
    end

    // smallest values: one-line frames, a frame starts on every tick
    run_to_frame_start();
    wait_drain();
    write_timing(1, 0, 0, 0, 1, 1, 0, 0);
    pick_gaps();
    send_random(60);

    // largest values: the active end lies far beyond the counter, so the
    // active phase never ends and each row repeats 256 times
    run_to_frame_start();
    wait_drain();
    write_timing(1023, 1, 2, 255, 255, 255, 1023, 1);
    pick_gaps();
    send_random(150);

    // still active and endless: one row per line, so the row offset wraps
    wait_drain();
    write_timing(1023, 1023, 1023, 0, 255, 255, 0, 1);
    pick_gaps();
    send_random(1000);

    // back to a short frame; the active phase ends once the counter reaches it
    wait_drain();
    write_random_timing();
    run_to_frame_start();

    // last stretch at full rate on both sides
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random(100);

    wait_drain();
    repeat (6) @(posedge clk);
    $display("%0d command beats, %0d lines checked: %0d drawn, %0d captured, %0d data lines",
             board.commands, board.lines_checked, board.kind_seen[int'(LK_DRAW)],
             board.kind_seen[int'(LK_CAPTURE)], board.kind_seen[int'(LK_DATA)]);
    $display("%0d frame starts, %0d tone stops, %0d vblank starts, %0d mismatches",
             board.frame_starts, board.tone_stops, board.vblanks, board.mismatches);
    if (board.mismatches == 0 && board.lines_due.size() == 0) begin
      $display("video_scanline_sequencer_tb OK");
    end else begin
      $display("video_scanline_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vss_pkg.sv
sv/vss_cmd_if.sv
sv/vss_res_if.sv
sv/video_scanline_sequencer.sv
sim/video_scanline_sequencer_tb.sv
